[design/ncms_pkg.sv]
// Shared widths, codes and types for the nearest-centroid metric scorer.
`default_nettype none

package ncms_pkg;

    // Defaults for the top-level parameters.
    localparam int          FEATURE_WIDTH_DEF = 24;
    localparam int unsigned MAX_OBJECTS_DEF   = 32'd65535;

    // Counter and accuracy widths fixed by the result fields.
    localparam int CNT_W     = 16;
    localparam int ACC_W     = 14;
    localparam int ACC_SCALE = 10000;
    localparam int DVD_W     = CNT_W + ACC_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_P1_AREA      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_P1_PERIMETER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P1_VERTICES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P2_AREA      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_P2_PERIMETER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_P2_VERTICES  = 3'd5;
    localparam int NUM_CFG = 6;

    // Class labels that can score a hit.
    localparam logic [1:0] CLASS_ONE = 2'd1;
    localparam logic [1:0] CLASS_TWO = 2'd2;

    // Best metric codes.
    localparam logic [1:0] BEST_TIE  = 2'd0;
    localparam logic [1:0] BEST_CHEB = 2'd1;
    localparam logic [1:0] BEST_MANH = 2'd2;
    localparam logic [1:0] BEST_EUCL = 2'd3;

    // Metric selector used while the divider runs.
    localparam logic [1:0] MET_CHEB = 2'd0;
    localparam logic [1:0] MET_MANH = 2'd1;
    localparam logic [1:0] MET_EUCL = 2'd2;

    // Divider status.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[design/ncms_div.sv]
// Iterative restoring divider for the accuracy ratio, one quotient bit per cycle.
`default_nettype none

module ncms_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ncms_pkg::DVD_W-1:0]    dividend,
    input  wire logic [ncms_pkg::CNT_W-1:0]    divisor,
    output logic      [ncms_pkg::ACC_W-1:0]    quotient,
    output ncms_pkg::div_stat_t                stat
);
    import ncms_pkg::*;

    localparam int STEP_W = $clog2(ACC_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [ACC_W-1:0]  sh_reg, sh_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    reduced;
    logic              fits;

    // One trial subtraction per cycle; the quotient shifts in at the bottom.
    assign trial   = {rem_reg, sh_reg[ACC_W-1]};
    assign reduced = trial - {1'b0, dsr_reg};
    assign fits    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            // The quotient is known to fit ACC_W bits, so the top part starts below the divisor.
            busy_next = 1'b1;
            cnt_next  = STEP_W'(ACC_W);
            rem_next  = dividend[DVD_W-1:ACC_W];
            sh_next   = dividend[ACC_W-1:0];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? reduced[CNT_W-1:0] : trial[CNT_W-1:0];
            sh_next  = {sh_reg[ACC_W-2:0], fits};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = sh_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

[design/nearest_centroid_metric_scorer.sv]
// Top level of the nearest-centroid metric scorer: sequencer, distance datapath and counters.
//
// Each object transfer yields one result transfer. Once the result side is free the block
// is ready again after each object: one subtract and one squaring multiplier step through
// the six feature differences (both prototypes), the pipeline drains, then the distances
// are compared and the hit counters updated. An object marked last adds three divisions
// on the shared bit-serial divider, which turns the hit counts into accuracies in
// hundredths of a percent. A finished result waits in the output register while the
// next object is already taken. The user must write prototype registers through the
// configuration port only while the block is idle; the block does not enforce this.
`default_nettype none

module nearest_centroid_metric_scorer #(
    parameter int          FEATURE_WIDTH = ncms_pkg::FEATURE_WIDTH_DEF,
    parameter int unsigned MAX_OBJECTS   = ncms_pkg::MAX_OBJECTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration port
    input  wire logic                              cfg_we,
    input  wire logic [ncms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [FEATURE_WIDTH-1:0]          cfg_data,
    // Object channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [FEATURE_WIDTH-1:0]   obj_area,
    input  wire logic signed [FEATURE_WIDTH-1:0]   obj_perimeter,
    input  wire logic signed [FEATURE_WIDTH-1:0]   obj_vertices,
    input  wire logic [1:0]                        true_class,
    input  wire logic                              last_object,
    // Result channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ncms_pkg::CNT_W-1:0]             cheb_hits,
    output logic [ncms_pkg::CNT_W-1:0]             manh_hits,
    output logic [ncms_pkg::CNT_W-1:0]             eucl_hits,
    output logic [ncms_pkg::ACC_W-1:0]             cheb_accuracy,
    output logic [ncms_pkg::ACC_W-1:0]             manh_accuracy,
    output logic [ncms_pkg::ACC_W-1:0]             eucl_accuracy,
    output logic [1:0]                             best_metric,
    output logic                                   report_valid
);
    import ncms_pkg::*;

    localparam int FW = FEATURE_WIDTH;
    localparam int MW = FW + 2;
    localparam int PW = 2 * FW;
    localparam int SW = PW + 2;
    localparam logic [CNT_W-1:0] CNT_CAP =
        (MAX_OBJECTS < 32'd65535) ? CNT_W'(MAX_OBJECTS) : {CNT_W{1'b1}};

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIST = 7'b0000010,
        ST_CMP  = 7'b0000100,
        ST_CNT  = 7'b0001000,
        ST_DIVL = 7'b0010000,
        ST_DIVW = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration and captured object.
    logic [FW-1:0]        proto_reg [0:NUM_CFG-1];
    logic [FW-1:0]        proto_next [0:NUM_CFG-1];
    logic signed [FW-1:0] x_reg [0:2];
    logic signed [FW-1:0] x_next [0:2];
    logic [1:0]           cls_reg, cls_next;
    logic                 last_reg, last_next;

    // Distance pipeline.
    logic [CFG_IDX_W-1:0] step_reg, step_next;
    logic                 dv_reg, dv_next;
    logic                 pv_reg, pv_next;
    logic                 dtag_reg, dtag_next;
    logic                 ptag_reg, ptag_next;
    logic [FW-1:0]        d_reg, d_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [FW-1:0]        cheb_reg [0:1];
    logic [FW-1:0]        cheb_next [0:1];
    logic [MW-1:0]        manh_reg [0:1];
    logic [MW-1:0]        manh_next [0:1];
    logic [SW-1:0]        sq_reg [0:1];
    logic [SW-1:0]        sq_next [0:1];

    // Hit decisions and counters.
    logic                 hc_reg, hc_next;
    logic                 hm_reg, hm_next;
    logic                 he_reg, he_next;
    logic [CNT_W-1:0]     cheb_cnt_reg, cheb_cnt_next;
    logic [CNT_W-1:0]     manh_cnt_reg, manh_cnt_next;
    logic [CNT_W-1:0]     eucl_cnt_reg, eucl_cnt_next;
    logic [CNT_W-1:0]     obj_cnt_reg, obj_cnt_next;

    // Accuracy division.
    logic [1:0]           met_reg, met_next;
    logic [ACC_W-1:0]     acc_c_reg, acc_c_next;
    logic [ACC_W-1:0]     acc_m_reg, acc_m_next;
    logic [ACC_W-1:0]     acc_e_reg, acc_e_next;
    logic                 div_start;
    logic [CNT_W-1:0]     div_hits;
    logic [DVD_W-1:0]     div_dividend;
    logic [ACC_W-1:0]     div_quot;
    div_stat_t            div_stat;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]     o_ch_reg, o_ch_next;
    logic [CNT_W-1:0]     o_mh_reg, o_mh_next;
    logic [CNT_W-1:0]     o_eh_reg, o_eh_next;
    logic [ACC_W-1:0]     o_ca_reg, o_ca_next;
    logic [ACC_W-1:0]     o_ma_reg, o_ma_next;
    logic [ACC_W-1:0]     o_ea_reg, o_ea_next;
    logic [1:0]           o_best_reg, o_best_next;
    logic                 o_rep_reg, o_rep_next;

    // Datapath operands and helpers.
    logic [FW-1:0]        x_sel;
    logic [FW-1:0]        p_sel;
    logic                 sel_tag;
    logic [FW:0]          diff_w;
    logic [FW:0]          neg_w;
    logic [1:0]           best_w;
    logic                 out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // Operand selection for the current step: prototype entry and matching feature.
    always_comb
    begin
        x_sel   = x_reg[0];
        p_sel   = proto_reg[0];
        sel_tag = 1'b0;
        case (step_reg)
            CFG_P1_AREA:
            begin
                x_sel = x_reg[0]; p_sel = proto_reg[0]; sel_tag = 1'b0;
            end
            CFG_P1_PERIMETER:
            begin
                x_sel = x_reg[1]; p_sel = proto_reg[1]; sel_tag = 1'b0;
            end
            CFG_P1_VERTICES:
            begin
                x_sel = x_reg[2]; p_sel = proto_reg[2]; sel_tag = 1'b0;
            end
            CFG_P2_AREA:
            begin
                x_sel = x_reg[0]; p_sel = proto_reg[3]; sel_tag = 1'b1;
            end
            CFG_P2_PERIMETER:
            begin
                x_sel = x_reg[1]; p_sel = proto_reg[4]; sel_tag = 1'b1;
            end
            CFG_P2_VERTICES:
            begin
                x_sel = x_reg[2]; p_sel = proto_reg[5]; sel_tag = 1'b1;
            end
            default:
            begin
                x_sel = x_reg[0]; p_sel = proto_reg[0]; sel_tag = 1'b0;
            end
        endcase
    end

    // Absolute difference, one extra bit so the subtraction cannot overflow.
    assign diff_w = {x_sel[FW-1], x_sel} - {p_sel[FW-1], p_sel};
    assign neg_w  = ~diff_w + (FW+1)'(1);

    // Best metric: strictly more hits than both others.
    always_comb
    begin
        if ((cheb_cnt_reg > manh_cnt_reg) && (cheb_cnt_reg > eucl_cnt_reg))
        begin
            best_w = BEST_CHEB;
        end
        else if ((manh_cnt_reg > cheb_cnt_reg) && (manh_cnt_reg > eucl_cnt_reg))
        begin
            best_w = BEST_MANH;
        end
        else if ((eucl_cnt_reg > cheb_cnt_reg) && (eucl_cnt_reg > manh_cnt_reg))
        begin
            best_w = BEST_EUCL;
        end
        else
        begin
            best_w = BEST_TIE;
        end
    end

    // Dividend for the metric under division.
    always_comb
    begin
        case (met_reg)
            MET_CHEB: div_hits = cheb_cnt_reg;
            MET_MANH: div_hits = manh_cnt_reg;
            MET_EUCL: div_hits = eucl_cnt_reg;
            default:  div_hits = cheb_cnt_reg;
        endcase
    end

    assign div_dividend = DVD_W'(div_hits) * DVD_W'(ACC_SCALE);
    assign div_start    = (state_reg == ST_DIVL);

    ncms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (obj_cnt_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // Sequencer and next-value logic.
    always_comb
    begin
        state_next     = state_reg;
        proto_next     = proto_reg;
        x_next         = x_reg;
        cls_next       = cls_reg;
        last_next      = last_reg;
        step_next      = step_reg;
        dv_next        = 1'b0;
        pv_next        = dv_reg;
        dtag_next      = sel_tag;
        ptag_next      = dtag_reg;
        d_next         = diff_w[FW] ? neg_w[FW-1:0] : diff_w[FW-1:0];
        prod_next      = PW'(d_reg) * PW'(d_reg);
        cheb_next      = cheb_reg;
        manh_next      = manh_reg;
        sq_next        = sq_reg;
        hc_next        = hc_reg;
        hm_next        = hm_reg;
        he_next        = he_reg;
        cheb_cnt_next  = cheb_cnt_reg;
        manh_cnt_next  = manh_cnt_reg;
        eucl_cnt_next  = eucl_cnt_reg;
        obj_cnt_next   = obj_cnt_reg;
        met_next       = met_reg;
        acc_c_next     = acc_c_reg;
        acc_m_next     = acc_m_reg;
        acc_e_next     = acc_e_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_ch_next      = o_ch_reg;
        o_mh_next      = o_mh_reg;
        o_eh_next      = o_eh_reg;
        o_ca_next      = o_ca_reg;
        o_ma_next      = o_ma_reg;
        o_ea_next      = o_ea_reg;
        o_best_next    = o_best_reg;
        o_rep_next     = o_rep_reg;

        // Prototype register writes.
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_P1_AREA:      proto_next[0] = cfg_data;
                CFG_P1_PERIMETER: proto_next[1] = cfg_data;
                CFG_P1_VERTICES:  proto_next[2] = cfg_data;
                CFG_P2_AREA:      proto_next[3] = cfg_data;
                CFG_P2_PERIMETER: proto_next[4] = cfg_data;
                CFG_P2_VERTICES:  proto_next[5] = cfg_data;
                default:          ;
            endcase
        end

        // Distance accumulation runs alongside the step issue.
        if (dv_reg)
        begin
            if (d_reg > cheb_reg[dtag_reg])
            begin
                cheb_next[dtag_reg] = d_reg;
            end
            manh_next[dtag_reg] = manh_reg[dtag_reg] + MW'(d_reg);
        end
        if (pv_reg)
        begin
            sq_next[ptag_reg] = sq_reg[ptag_reg] + SW'(prod_reg);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next[0] = obj_area;
                    x_next[1] = obj_perimeter;
                    x_next[2] = obj_vertices;
                    cls_next  = true_class;
                    last_next = last_object;
                    step_next = CFG_P1_AREA;
                    cheb_next[0] = '0;
                    cheb_next[1] = '0;
                    manh_next[0] = '0;
                    manh_next[1] = '0;
                    sq_next[0]   = '0;
                    sq_next[1]   = '0;
                    state_next   = ST_DIST;
                end
            end
            ST_DIST:
            begin
                // Issue one feature difference per cycle, then let the pipeline drain.
                if (step_reg != CFG_IDX_W'(NUM_CFG))
                begin
                    dv_next   = 1'b1;
                    step_next = step_reg + CFG_IDX_W'(1);
                end
                else if (!dv_reg && !pv_reg)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                hc_next = ((cheb_reg[0] < cheb_reg[1]) && (cls_reg == CLASS_ONE)) ||
                          ((cheb_reg[0] > cheb_reg[1]) && (cls_reg == CLASS_TWO));
                hm_next = ((manh_reg[0] < manh_reg[1]) && (cls_reg == CLASS_ONE)) ||
                          ((manh_reg[0] > manh_reg[1]) && (cls_reg == CLASS_TWO));
                he_next = ((sq_reg[0] < sq_reg[1]) && (cls_reg == CLASS_ONE)) ||
                          ((sq_reg[0] > sq_reg[1]) && (cls_reg == CLASS_TWO));
                state_next = ST_CNT;
            end
            ST_CNT:
            begin
                // Saturating counter updates.
                if (hc_reg && (cheb_cnt_reg < CNT_CAP))
                begin
                    cheb_cnt_next = cheb_cnt_reg + CNT_W'(1);
                end
                if (hm_reg && (manh_cnt_reg < CNT_CAP))
                begin
                    manh_cnt_next = manh_cnt_reg + CNT_W'(1);
                end
                if (he_reg && (eucl_cnt_reg < CNT_CAP))
                begin
                    eucl_cnt_next = eucl_cnt_reg + CNT_W'(1);
                end
                if (obj_cnt_reg < CNT_CAP)
                begin
                    obj_cnt_next = obj_cnt_reg + CNT_W'(1);
                end
                met_next   = MET_CHEB;
                state_next = last_reg ? ST_DIVL : ST_DONE;
            end
            ST_DIVL:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    case (met_reg)
                        MET_CHEB: acc_c_next = div_quot;
                        MET_MANH: acc_m_next = div_quot;
                        MET_EUCL: acc_e_next = div_quot;
                        default:  ;
                    endcase
                    if (met_reg == MET_EUCL)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        met_next   = met_reg + 2'd1;
                        state_next = ST_DIVL;
                    end
                end
            end
            ST_DONE:
            begin
                // Load the output register once it is free; a report clears the batch.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_ch_next      = cheb_cnt_reg;
                    o_mh_next      = manh_cnt_reg;
                    o_eh_next      = eucl_cnt_reg;
                    o_ca_next      = last_reg ? acc_c_reg : '0;
                    o_ma_next      = last_reg ? acc_m_reg : '0;
                    o_ea_next      = last_reg ? acc_e_reg : '0;
                    o_best_next    = last_reg ? best_w : BEST_TIE;
                    o_rep_next     = last_reg;
                    if (last_reg)
                    begin
                        cheb_cnt_next = '0;
                        manh_cnt_next = '0;
                        eucl_cnt_next = '0;
                        obj_cnt_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            dv_reg        <= 1'b0;
            pv_reg        <= 1'b0;
            cheb_cnt_reg  <= '0;
            manh_cnt_reg  <= '0;
            eucl_cnt_reg  <= '0;
            obj_cnt_reg   <= '0;
            met_reg       <= MET_CHEB;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CFG; i++)
            begin
                proto_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            dv_reg        <= dv_next;
            pv_reg        <= pv_next;
            cheb_cnt_reg  <= cheb_cnt_next;
            manh_cnt_reg  <= manh_cnt_next;
            eucl_cnt_reg  <= eucl_cnt_next;
            obj_cnt_reg   <= obj_cnt_next;
            met_reg       <= met_next;
            out_valid_reg <= out_valid_next;
            proto_reg     <= proto_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        cls_reg    <= cls_next;
        last_reg   <= last_next;
        dtag_reg   <= dtag_next;
        ptag_reg   <= ptag_next;
        d_reg      <= d_next;
        prod_reg   <= prod_next;
        cheb_reg   <= cheb_next;
        manh_reg   <= manh_next;
        sq_reg     <= sq_next;
        hc_reg     <= hc_next;
        hm_reg     <= hm_next;
        he_reg     <= he_next;
        acc_c_reg  <= acc_c_next;
        acc_m_reg  <= acc_m_next;
        acc_e_reg  <= acc_e_next;
        o_ch_reg   <= o_ch_next;
        o_mh_reg   <= o_mh_next;
        o_eh_reg   <= o_eh_next;
        o_ca_reg   <= o_ca_next;
        o_ma_reg   <= o_ma_next;
        o_ea_reg   <= o_ea_next;
        o_best_reg <= o_best_next;
        o_rep_reg  <= o_rep_next;
    end

    assign out_valid     = out_valid_reg;
    assign cheb_hits     = o_ch_reg;
    assign manh_hits     = o_mh_reg;
    assign eucl_hits     = o_eh_reg;
    assign cheb_accuracy = o_ca_reg;
    assign manh_accuracy = o_ma_reg;
    assign eucl_accuracy = o_ea_reg;
    assign best_metric   = o_best_reg;
    assign report_valid  = o_rep_reg;

    // Hit counts never run ahead of the object count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cheb_cnt_reg <= obj_cnt_reg) && (manh_cnt_reg <= obj_cnt_reg) &&
        (eucl_cnt_reg <= obj_cnt_reg))
        else $error("hit count exceeds object count");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVW))
        else $error("divider finished outside the division wait");

    // A result that is not a report carries no accuracies and no best metric.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !report_valid) |->
        ((cheb_accuracy == '0) && (manh_accuracy == '0) && (eucl_accuracy == '0) &&
         (best_metric == BEST_TIE)))
        else $error("report fields set on a plain result");

    // A report never exceeds one hundred percent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && report_valid) |->
        ((cheb_accuracy <= ACC_W'(ACC_SCALE)) && (manh_accuracy <= ACC_W'(ACC_SCALE)) &&
         (eucl_accuracy <= ACC_W'(ACC_SCALE))))
        else $error("accuracy above full scale");

endmodule

`default_nettype wire
